>>> sv/assignment_solver_hungarian_assert.svh
// Assertion macros used by the checker of the assignment solver.
`ifndef ASSIGNMENT_SOLVER_HUNGARIAN_ASSERT_SVH
`define ASSIGNMENT_SOLVER_HUNGARIAN_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define ASH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: consequent does not hold");

// Next-cycle implication, checked during reset too.
`define ASH_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle consequent does not hold");

`endif

>>> sv/ash_pkg.sv
`timescale 1ns / 1ps
package ash_pkg;

  localparam int DEF_MAX_DIM   = 32;
  localparam int DEF_COST_BITS = 32;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // Index width for n entries, at least one bit.
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

>>> sv/assignment_solver_hungarian.sv
`timescale 1ns / 1ps
// Minimum-cost assignment solver, Hungarian method with row/column potentials.
// Channels:
//   cfg:    cfg_valid/cfg_ready write of rows_in_use (index 0) or cols_in_use
//           (index 1); cfg_ready is always high. Write only while busy is low.
//   input:  one cost per transaction, row-major, taken when start && !busy.
//           Loading runs at one entry per cycle; busy stays low until the
//           entry that completes the rows x cols matrix.
//   result: one transaction per real row, strobed by result_valid for one
//           cycle each, in row order; total_cost and cost_invalid are valid
//           with last. The receiver cannot stall, so results stream out on
//           consecutive cycles.
// Solve: after the final entry the solve walks a column memory, each access a
//   read state followed by a done state: a pass over the columns starts each
//   row phase, each augmenting step scans and then updates the columns, and
//   the path back to column 0 is followed hop by hop. Readout then walks the
//   columns and reads the cost of each matched pair, followed by one result
//   transaction per row in use.
// Reset: both sizes return to 1, the load count clears, any solve is dropped.
//   The cost memory is not cleared; entries are defined once loaded.
module assignment_solver_hungarian #(
  parameter int MAX_DIM   = ash_pkg::DEF_MAX_DIM,
  parameter int COST_BITS = ash_pkg::DEF_COST_BITS,
  localparam int RW       = ash_pkg::idx_bits(MAX_DIM),
  localparam int TOT_W    = COST_BITS + RW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ash_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ash_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COST_BITS-1:0]   cost_value,
  input  logic                          cost_forbidden,
  output logic                          result_valid,
  output logic [RW-1:0]                 row_index,
  output logic [RW-1:0]                 assigned_column,
  output logic                          has_column,
  output logic signed [TOT_W-1:0]       total_cost,
  output logic                          cost_invalid,
  output logic                          last
);
  import ash_pkg::*;

  localparam int IW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = idx_bits(DEPTH);
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int PW    = COST_BITS + 16;
  localparam logic signed [PW-1:0] PAD  = PW'(1) << (COST_BITS + 7);
  localparam logic signed [PW-1:0] HALF = PW'(1) << (COST_BITS + 6);

  typedef struct packed {
    logic [IW-1:0]        match;
    logic signed [PW-1:0] u;
    logic signed [PW-1:0] v;
    logic signed [PW-1:0] slack;
    logic                 sinf;
    logic [IW-1:0]        back;
    logic                 vis;
  } ent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_CLR_R, ST_CLR_D, ST_C0_R, ST_C0_D, ST_SA_R, ST_SA_D,
    ST_SB_R, ST_SB_D, ST_AUG_R1, ST_AUG_D1, ST_AUG_R2, ST_AUG_D2,
    ST_OC_R, ST_OC_D, ST_OC_C, ST_OC_CD, ST_EMIT
  } state_t;

  // column memory: per-column potential, slack, links and the potential of
  // the row matched to that column
  ent_t                 cmem [MAX_DIM+1];
  logic                 cm_we;
  logic [IW-1:0]        cm_wa, cm_ra;
  ent_t                 cm_wd, cm_rd;

  logic [COST_BITS:0]   smem [DEPTH];
  logic                 sm_we;
  logic [AW-1:0]        sm_wa, sm_ra;
  logic [COST_BITS:0]   sm_wd, sm_rd;

  state_t               state;
  logic [IW-1:0]        rows, cols;
  logic [LCW-1:0]       cnt;
  logic [IW-1:0]        i, j, c0, c1, b;
  logic signed [PW-1:0] ur0, delta;
  logic                 dinf, row_pad;
  logic [AW-1:0]        base, caddr;
  ent_t                 ent_c0;
  logic [RW-1:0]        asg_col [MAX_DIM];
  logic                 asg_ok  [MAX_DIM];
  logic signed [TOT_W-1:0] total;
  logic                 inval;
  logic [RW-1:0]        r;

  logic [IW-1:0]        dim, jm1, rm1;
  logic [LCW-1:0]       total_n, cnt_next;
  logic [2*IW-1:0]      prod;
  logic signed [PW-1:0] cost_sx, cval, cur, ns;
  logic signed [TOT_W-1:0] cost_tot;
  logic                 col_pad, take, better, accept, last_now, pair_ok;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign dim       = (rows > cols) ? rows : cols;
  assign jm1       = j - IW'(1);
  assign rm1       = cm_rd.match - IW'(1);
  assign prod      = rm1 * cols;
  assign total_n   = LCW'(rows) * LCW'(cols);
  assign cnt_next  = cnt + LCW'(1);
  assign cost_sx   = PW'($signed(sm_rd[COST_BITS-1:0]));
  assign cost_tot  = TOT_W'($signed(sm_rd[COST_BITS-1:0]));
  assign col_pad   = (jm1 >= cols);
  assign cval      = (row_pad || col_pad) ? PAD : (sm_rd[COST_BITS] ? HALF : cost_sx);
  assign cur       = cval - ur0 - cm_rd.v;
  assign take      = cm_rd.sinf || (cur < cm_rd.slack);
  assign ns        = take ? cur : cm_rd.slack;
  assign better    = dinf || (ns < delta);
  assign last_now  = ((IW'(r) + IW'(1)) == rows);
  assign pair_ok   = (cm_rd.match != '0) && (cm_rd.match <= rows) && (j <= cols);

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_wa] <= cm_wd;
    cm_rd <= cmem[cm_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_wa] <= sm_wd;
    sm_rd <= smem[sm_ra];
  end

  always_comb begin
    cm_we = 1'b0;
    cm_wa = j;
    cm_ra = j;
    cm_wd = cm_rd;
    sm_we = 1'b0;
    sm_wa = cnt[AW-1:0];
    sm_wd = {cost_forbidden, cost_value};
    sm_ra = base + AW'(jm1);
    case (state)
      ST_IDLE: sm_we = accept;
      ST_INIT: begin
        cm_we      = 1'b1;
        cm_wd      = '0;
        cm_wd.sinf = 1'b1;
      end
      ST_CLR_D: begin
        cm_we      = 1'b1;
        cm_wd.vis  = 1'b0;
        cm_wd.sinf = 1'b1;
        if (j == '0) begin
          cm_wd.match = i;
          cm_wd.u     = '0;
        end
      end
      ST_C0_R: cm_ra = c0;
      ST_C0_D: begin
        cm_we     = (cm_rd.match != '0);
        cm_wa     = c0;
        cm_wd.vis = 1'b1;
      end
      ST_SA_D: begin
        cm_we       = !cm_rd.vis;
        cm_wd.slack = ns;
        cm_wd.sinf  = 1'b0;
        if (take) cm_wd.back = c0;
      end
      ST_SB_D: begin
        cm_we = 1'b1;
        if (cm_rd.vis) begin
          cm_wd.u = cm_rd.u + delta;
          cm_wd.v = cm_rd.v - delta;
        end else if (!cm_rd.sinf) begin
          cm_wd.slack = cm_rd.slack - delta;
        end
      end
      ST_AUG_R1: cm_ra = c0;
      ST_AUG_R2: cm_ra = b;
      ST_AUG_D2: begin
        cm_we       = 1'b1;
        cm_wa       = c0;
        cm_wd       = ent_c0;
        cm_wd.match = cm_rd.match;
        cm_wd.u     = cm_rd.u;
      end
      ST_OC_C: sm_ra = caddr;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rows         <= IW'(1);
      cols         <= IW'(1);
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS || cfg_index == REG_COLS) begin
          if (cfg_data == '0) begin
            if (cfg_index == REG_ROWS) rows <= IW'(1);
            else cols <= IW'(1);
          end else if (int'(cfg_data) > MAX_DIM) begin
            if (cfg_index == REG_ROWS) rows <= IW'(MAX_DIM);
            else cols <= IW'(MAX_DIM);
          end else begin
            if (cfg_index == REG_ROWS) rows <= IW'(cfg_data);
            else cols <= IW'(cfg_data);
          end
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cnt_next >= total_n) begin
              cnt   <= '0;
              j     <= '0;
              state <= ST_INIT;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        ST_INIT: begin
          if (j == dim) begin
            for (int k = 0; k < MAX_DIM; k++) asg_ok[k] <= 1'b0;
            total <= '0;
            inval <= 1'b0;
            i     <= IW'(1);
            j     <= '0;
            state <= ST_CLR_R;
          end else begin
            j <= j + IW'(1);
          end
        end
        ST_CLR_R: state <= ST_CLR_D;
        ST_CLR_D: begin
          if (j == dim) begin
            c0    <= '0;
            state <= ST_C0_R;
          end else begin
            j     <= j + IW'(1);
            state <= ST_CLR_R;
          end
        end
        ST_C0_R: state <= ST_C0_D;
        ST_C0_D: begin
          if (cm_rd.match == '0) begin
            state <= ST_AUG_R1;
          end else begin
            ur0     <= cm_rd.u;
            base    <= AW'(prod);
            row_pad <= (rm1 >= rows);
            dinf    <= 1'b1;
            c1      <= '0;
            j       <= IW'(1);
            state   <= ST_SA_R;
          end
        end
        ST_SA_R: state <= ST_SA_D;
        ST_SA_D: begin
          if (!cm_rd.vis && better) begin
            delta <= ns;
            dinf  <= 1'b0;
            c1    <= j;
          end
          if (j == dim) begin
            j     <= '0;
            state <= ST_SB_R;
          end else begin
            j     <= j + IW'(1);
            state <= ST_SA_R;
          end
        end
        ST_SB_R: state <= ST_SB_D;
        ST_SB_D: begin
          if (j == dim) begin
            c0    <= c1;
            state <= ST_C0_R;
          end else begin
            j     <= j + IW'(1);
            state <= ST_SB_R;
          end
        end
        ST_AUG_R1: state <= ST_AUG_D1;
        ST_AUG_D1: begin
          ent_c0 <= cm_rd;
          b      <= cm_rd.back;
          state  <= ST_AUG_R2;
        end
        ST_AUG_R2: state <= ST_AUG_D2;
        ST_AUG_D2: begin
          c0 <= b;
          if (b != '0) begin
            state <= ST_AUG_R1;
          end else if (i == dim) begin
            j     <= IW'(1);
            state <= ST_OC_R;
          end else begin
            i     <= i + IW'(1);
            j     <= '0;
            state <= ST_CLR_R;
          end
        end
        ST_OC_R: state <= ST_OC_D;
        ST_OC_D: begin
          if (pair_ok) begin
            asg_col[rm1[RW-1:0]] <= RW'(jm1);
            asg_ok[rm1[RW-1:0]]  <= 1'b1;
            caddr                <= AW'(prod) + AW'(jm1);
            state                <= ST_OC_C;
          end else if (j == dim) begin
            r     <= '0;
            state <= ST_EMIT;
          end else begin
            j     <= j + IW'(1);
            state <= ST_OC_R;
          end
        end
        ST_OC_C: state <= ST_OC_CD;
        ST_OC_CD: begin
          if (sm_rd[COST_BITS]) inval <= 1'b1;
          else total <= total + cost_tot;
          if (j == dim) begin
            r     <= '0;
            state <= ST_EMIT;
          end else begin
            j     <= j + IW'(1);
            state <= ST_OC_R;
          end
        end
        ST_EMIT: begin
          result_valid    <= 1'b1;
          row_index       <= r;
          has_column      <= asg_ok[r];
          assigned_column <= asg_ok[r] ? asg_col[r] : '0;
          last            <= last_now;
          total_cost      <= last_now ? total : '0;
          cost_invalid    <= last_now && inval;
          r               <= r + RW'(1);
          if (last_now) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ash_checker.sv
`timescale 1ns / 1ps
`include "assignment_solver_hungarian_assert.svh"
module ash_checker #(
  parameter int MAX_DIM   = ash_pkg::DEF_MAX_DIM,
  parameter int COST_BITS = ash_pkg::DEF_COST_BITS,
  localparam int RW       = ash_pkg::idx_bits(MAX_DIM),
  localparam int TOT_W    = COST_BITS + RW
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    result_valid,
  input logic [RW-1:0]           assigned_column,
  input logic                    has_column,
  input logic signed [TOT_W-1:0] total_cost,
  input logic                    cost_invalid,
  input logic                    last
);
  import ash_pkg::*;

  // results before the final one come out of a running solve with no summary
  `ASH_ASSERT_IMP(a_mid_result, clk, rst, result_valid && !last, busy && total_cost == '0 && !cost_invalid)
  `ASH_ASSERT_IMP(a_no_col_zero, clk, rst, result_valid && !has_column, assigned_column == '0)
  // a load transaction never lands while results are still pending
  `ASH_ASSERT_NEXT(a_load_quiet, clk, !rst && start && !busy, !result_valid)
  `ASH_ASSERT_NEXT(a_reset_quiet, clk, rst, !result_valid && !busy)

endmodule

bind assignment_solver_hungarian ash_checker #(
  .MAX_DIM(MAX_DIM),
  .COST_BITS(COST_BITS)
) u_ash_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .result_valid(result_valid),
  .assigned_column(assigned_column),
  .has_column(has_column),
  .total_cost(total_cost),
  .cost_invalid(cost_invalid),
  .last(last)
);

>>> tb/assignment_solver_hungarian_tb.sv
`timescale 1ns / 1ps
module assignment_solver_hungarian_tb;
  import ash_pkg::*;

  localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LMIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam longint PAD = 64'sd1 << (DEF_COST_BITS + 7);
  localparam int QUIET_CYCLES = 8;
  localparam int CYCLE_LIMIT = 6000000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int { OP_COST, OP_CFG, OP_DRAIN } op_kind_t;

  typedef struct {
    op_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    logic [31:0] val;
    bit forb;
    int idle;
  } stim_op_t;

  typedef struct {
    logic [4:0] row;
    logic [4:0] col;
    bit has;
    logic [36:0] tot;
    bit inv;
    bit lst;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] cost_value = '0;
  logic cost_forbidden = 1'b0;
  logic result_valid;
  logic [4:0] row_index;
  logic [4:0] assigned_column;
  logic has_column;
  logic signed [36:0] total_cost;
  logic cost_invalid;
  logic last;

  assignment_solver_hungarian u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .cost_value(cost_value), .cost_forbidden(cost_forbidden),
    .result_valid(result_valid), .row_index(row_index), .assigned_column(assigned_column),
    .has_column(has_column), .total_cost(total_cost), .cost_invalid(cost_invalid),
    .last(last)
  );

  always #5 clk = ~clk;

  stim_op_t stim_q[$];
  row_result_t pending_rows[$];
  int errors = 0;
  int cycles = 0;
  int quiet = 0;

  // Shadow of the block: cost memory, sizes and load position.
  longint mem_val[1024];
  bit mem_forb[1024];
  int rows_n = 1;
  int cols_n = 1;
  int load_pos = 0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return int'(v);
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    if (b > 0 && a > LMAX - b) return LMAX;
    if (b < 0 && a < LMIN - b) return LMIN;
    return a + b;
  endfunction

  function automatic longint sat_sub(input longint a, input longint b);
    if (b < 0 && a > LMAX + b) return LMAX;
    if (b > 0 && a < LMIN + b) return LMIN;
    return a - b;
  endfunction

  function automatic longint padded_cost(input int i, input int j);
    int a;
    if (i >= rows_n || j >= cols_n) return PAD;
    a = (i * cols_n + j) % 1024;
    if (mem_forb[a]) return PAD / 2;
    return mem_val[a];
  endfunction

  // Solve the loaded matrix and queue one expected result per real row.
  function automatic void solve_assignment();
    longint u[33], v[33], minv[33];
    int p[33], way[33];
    bit used[33];
    int asg[32];
    int dim, i, j, c0, c1, r0, a;
    longint delta, cur, total;
    bit inv;
    row_result_t rr;
    dim = rows_n > cols_n ? rows_n : cols_n;
    for (j = 0; j <= 32; j++) begin
      u[j] = 0; v[j] = 0; p[j] = 0; way[j] = 0;
    end
    for (i = 1; i <= dim; i++) begin
      p[0] = i;
      c0 = 0;
      for (j = 0; j <= 32; j++) begin
        minv[j] = LMAX; used[j] = 0;
      end
      do begin
        r0 = p[c0];
        used[c0] = 1;
        delta = LMAX;
        c1 = 0;
        for (j = 1; j <= dim; j++) begin
          if (!used[j]) begin
            cur = sat_sub(sat_sub(padded_cost(r0 - 1, j - 1), u[r0]), v[j]);
            if (cur < minv[j]) begin
              minv[j] = cur; way[j] = c0;
            end
            if (minv[j] < delta) begin
              delta = minv[j]; c1 = j;
            end
          end
        end
        for (j = 0; j <= dim; j++) begin
          if (used[j]) begin
            u[p[j] % 33] = sat_add(u[p[j] % 33], delta);
            v[j] = sat_sub(v[j], delta);
          end else begin
            minv[j] = sat_sub(minv[j], delta);
          end
        end
        c0 = c1;
      end while (p[c0] != 0);
      do begin
        c1 = way[c0] % 33;
        p[c0] = p[c1];
        c0 = c1;
      end while (c0 != 0);
    end
    for (i = 0; i < 32; i++) asg[i] = -1;
    for (j = 1; j <= dim; j++)
      if (p[j] >= 1 && p[j] <= rows_n && j <= cols_n) asg[p[j] - 1] = j - 1;
    total = 0;
    inv = 0;
    for (i = 0; i < rows_n; i++) begin
      if (asg[i] >= 0) begin
        a = (i * cols_n + asg[i]) % 1024;
        if (mem_forb[a]) inv = 1;
        else total += mem_val[a];
      end
    end
    for (i = 0; i < rows_n; i++) begin
      rr.row = i[4:0];
      rr.has = asg[i] >= 0;
      rr.col = rr.has ? asg[i][4:0] : 5'd0;
      rr.lst = (i + 1 == rows_n);
      rr.tot = rr.lst ? total[36:0] : 37'd0;
      rr.inv = rr.lst && inv;
      pending_rows.push_back(rr);
    end
  endfunction

  function automatic void take_entry(input logic [31:0] val, input bit forb);
    mem_val[load_pos % 1024] = longint'($signed(val));
    mem_forb[load_pos % 1024] = forb;
    load_pos++;
    if (load_pos >= rows_n * cols_n) begin
      load_pos = 0;
      solve_assignment();
    end
  endfunction

  // Driver: accept, predict, then offer the next transaction.
  always @(posedge clk) begin
    bit nxt_start, nxt_cfg;
    nxt_start = 1'b0;
    nxt_cfg = 1'b0;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (start && !busy) take_entry(cost_value, cost_forbidden);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) rows_n = clamp_dim(cfg_data);
        else if (cfg_index == REG_COLS) cols_n = clamp_dim(cfg_data);
      end
      if (pending_rows.size() == 0 && !busy) quiet++;
      else quiet = 0;
      if (start && busy) begin
        nxt_start = 1'b1;  // hold until taken
      end else if (stim_q.size() > 0) begin
        if (stim_q[0].kind == OP_COST) begin
          if ($urandom_range(99) >= stim_q[0].idle) begin
            nxt_start = 1'b1;
            cost_value <= stim_q[0].val;
            cost_forbidden <= stim_q[0].forb;
            void'(stim_q.pop_front());
          end
        end else if (!start && !cfg_valid && quiet >= QUIET_CYCLES) begin
          if (stim_q[0].kind == OP_CFG) begin
            nxt_cfg = 1'b1;
            cfg_index <= stim_q[0].idx;
            cfg_data <= stim_q[0].data;
          end
          void'(stim_q.pop_front());
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    row_result_t rr;
    if (!rst && result_valid) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch($sformatf("unexpected result for row %0d", row_index));
      end else begin
        rr = pending_rows.pop_front();
        if (row_index !== rr.row)
          flag_mismatch($sformatf("row_index %0d, want %0d", row_index, rr.row));
        if (has_column !== rr.has)
          flag_mismatch($sformatf("row %0d has_column %0b, want %0b", rr.row, has_column, rr.has));
        if (assigned_column !== rr.col)
          flag_mismatch($sformatf("row %0d column %0d, want %0d", rr.row, assigned_column,
                                  rr.col));
        if (total_cost !== rr.tot)
          flag_mismatch($sformatf("row %0d total %0d, want %0d", rr.row, total_cost,
                                  $signed(rr.tot)));
        if (cost_invalid !== rr.inv)
          flag_mismatch($sformatf("row %0d cost_invalid %0b, want %0b", rr.row, cost_invalid,
                                  rr.inv));
        if (last !== rr.lst)
          flag_mismatch($sformatf("row %0d last %0b, want %0b", rr.row, last, rr.lst));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("assignment_solver_hungarian_tb: errors");
      $finish;
    end
  end

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    stim_op_t op;
    op.kind = OP_CFG; op.idx = idx; op.data = data; op.val = '0; op.forb = 0; op.idle = 0;
    stim_q.push_back(op);
  endtask

  task automatic push_cost(input logic [31:0] val, input bit forb, input int idle);
    stim_op_t op;
    op.kind = OP_COST; op.idx = '0; op.data = '0; op.val = val; op.forb = forb;
    op.idle = idle;
    stim_q.push_back(op);
  endtask

  function automatic logic [31:0] pick_cost(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(8)) - 4);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Size the matrix and fill it; mode picks the value spread, forb_pct the share forbidden.
  task automatic push_matrix(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
                             input int mode, input int forb_pct, input int idle);
    int n;
    push_cfg(REG_ROWS, r);
    push_cfg(REG_COLS, c);
    n = clamp_dim(r) * clamp_dim(c);
    for (int k = 0; k < n; k++)
      push_cost(pick_cost(mode), $urandom_range(99) < forb_pct, idle);
  endtask

  initial begin
    int sent, r, c, idle;
    stim_op_t drain;
    // directed part
    push_cfg(REG_ROWS, 6'd1);
    push_cost(32'h7FFF_FFFF, 0, 0);
    push_cost(32'h8000_0000, 0, 0);
    push_cost(32'h0000_0005, 1, 0);
    push_matrix(6'd2, 6'd2, 2, 0, 0);
    push_matrix(6'd3, 6'd2, 0, 0, 0);
    push_matrix(6'd2, 6'd3, 0, 0, 0);
    push_matrix(6'd3, 6'd3, 1, 0, 0);      // equal-slack ties
    push_cfg(REG_ROWS, 6'd3);
    push_cfg(REG_COLS, 6'd3);
    for (int k = 0; k < 9; k++) push_cost(32'd7, 0, 0);
    push_matrix(6'd2, 6'd2, 0, 100, 0);    // every entry forbidden
    push_cfg(REG_NONE, 6'd9);              // ignored index
    push_cfg(REG_SPARE, 6'd63);
    push_matrix(6'd0, 6'd0, 0, 20, 0);     // zero saturates to one
    push_matrix(6'd63, 6'd1, 0, 10, 10);   // above the limit saturates to 32
    push_matrix(6'd1, 6'd32, 0, 10, 48);
    drain.kind = OP_DRAIN; drain.idx = '0; drain.data = '0; drain.val = '0; drain.forb = 0;
    drain.idle = 0;
    // random part
    sent = 0;
    while (sent < 300) begin
      case ((sent / 60) % 3)
        0: idle = 0;
        1: idle = 48;
        default: idle = 10;
      endcase
      if ($urandom_range(9) == 0) stim_q.push_back(drain);
      if ($urandom_range(15) == 0) begin
        r = $urandom_range(32, 1); c = $urandom_range(3, 1);
      end else begin
        r = $urandom_range(5, 1); c = $urandom_range(5, 1);
      end
      if ($urandom_range(1)) begin
        int t;
        t = r; r = c; c = t;
      end
      push_matrix(r[CFG_W-1:0], c[CFG_W-1:0], $urandom_range(2), $urandom_range(1) ? 0 : 15,
                  idle);
      sent += r * c;
    end
    wait (rst == 1'b0);
    do @(posedge clk);
    while (stim_q.size() != 0 || start || busy || pending_rows.size() != 0);
    repeat (200) @(posedge clk);
    if (pending_rows.size() != 0)
      flag_mismatch($sformatf("%0d results never came", pending_rows.size()));
    if (errors == 0) begin
      $display("assignment_solver_hungarian_tb: clean");
    end else begin
      $display("assignment_solver_hungarian_tb: errors");
    end
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end
endmodule
